@@ src/sct_pkg.sv @@
`timescale 1ns / 1ps

package sct_pkg;

  // Series arithmetic works on unsigned magnitudes at 28 fractional bits.
  localparam int FRAC   = 28;
  localparam int MAG_W  = 30;   // reduced angle magnitude
  localparam int SQ_W   = 32;   // x squared
  localparam int TERM_W = 31;   // one series term
  localparam int ACC_W  = 33;   // signed running sum
  localparam int PROD_W = 34;   // term times x squared, rounded
  localparam int NUM_W  = 35;   // dividend of the constant division
  localparam int OUT_W  = 24;

  localparam logic [33:0] PI_Q32     = 34'd13493037705;
  localparam logic [34:0] TWO_PI_Q32 = 35'd26986075410;
  localparam logic [30:0] ONE_Q28    = 31'd268435456;
  localparam logic [63:0] HALF_Q28   = 64'd134217728;

  localparam logic [OUT_W-1:0] OUT_MAX = 24'h7FFFFF;
  localparam logic [OUT_W-1:0] OUT_MIN = 24'h800000;

  typedef struct packed {
    logic signed [ACC_W-1:0] s_acc;
    logic [TERM_W-1:0]       s_term;
    logic signed [ACC_W-1:0] c_acc;
    logic [TERM_W-1:0]       c_term;
    logic [SQ_W-1:0]         x2;
    logic                    neg;
  } term_bus_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] sine;
    logic signed [OUT_W-1:0] cosine;
  } result_t;

endpackage

@@ src/sct_in_if.sv @@
`timescale 1ns / 1ps

interface sct_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

@@ src/sct_out_if.sv @@
`timescale 1ns / 1ps

interface sct_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sine_value;
  logic signed [23:0] cosine_value;

  modport source (output valid, output sine_value, output cosine_value, input ready);
  modport sink (input valid, input sine_value, input cosine_value, output ready);
endinterface

@@ src/sct_reduce_cell.sv @@
`timescale 1ns / 1ps

module sct_reduce_cell
  import sct_pkg::*;
#(
  parameter int YW    = 41,
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          vin,
  input  logic [YW-1:0] yin,
  output logic          vout,
  output logic [YW-1:0] yout
);

  localparam logic [YW-1:0] STEP = YW'(TWO_PI_Q32) << SHIFT;

  logic [YW-1:0] y_next;

  // One bit of the quotient: take away this multiple of two pi if it fits.
  assign y_next = (yin >= STEP) ? yin - STEP : yin;

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (adv) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      yout <= y_next;
    end
  end

endmodule

@@ src/sct_term_cell.sv @@
`timescale 1ns / 1ps

module sct_term_cell
  import sct_pkg::*;
#(
  parameter int K      = 0,
  parameter bit SIN_ON = 1'b1,
  parameter bit COS_ON = 1'b1
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  logic      vin,
  input  term_bus_t bin,
  output logic      vout,
  output term_bus_t bout
);

  localparam int SIN_I = 2 * K + 3;
  localparam int COS_I = 2 * K + 2;
  localparam int SIN_D = SIN_I * (SIN_I - 1);
  localparam int COS_D = COS_I * (COS_I - 1);
  localparam bit SUBTRACT = (K % 2) == 0;

  localparam logic [NUM_W-1:0] SIN_DV   = NUM_W'(SIN_D);
  localparam logic [NUM_W-1:0] COS_DV   = NUM_W'(COS_D);
  localparam logic [NUM_W-1:0] SIN_HALF = NUM_W'(SIN_D / 2);
  localparam logic [NUM_W-1:0] COS_HALF = NUM_W'(COS_D / 2);
  localparam logic [NUM_W-1:0] SIN_M    = NUM_W'((64'd1 << NUM_W) / SIN_D);
  localparam logic [NUM_W-1:0] COS_M    = NUM_W'((64'd1 << NUM_W) / COS_D);

  // Stage A: previous term times x squared, rounded to 28 fractional bits.
  logic [62:0]       s_prod, c_prod;
  logic [PROD_W-1:0] s_p_next, c_p_next;
  term_bus_t         bus_a;
  logic [PROD_W-1:0] s_p, c_p;
  logic              va;

  assign s_prod   = 63'(bin.s_term) * 63'(bin.x2);
  assign c_prod   = 63'(bin.c_term) * 63'(bin.x2);
  assign s_p_next = PROD_W'((s_prod + 63'(HALF_Q28)) >> FRAC);
  assign c_p_next = PROD_W'((c_prod + 63'(HALF_Q28)) >> FRAC);

  // Stage B: quotient estimate by reciprocal, at most one short.
  logic [NUM_W-1:0]   s_n_next, c_n_next;
  logic [2*NUM_W-1:0] s_qprod, c_qprod;
  term_bus_t          bus_b;
  logic [NUM_W-1:0]   s_n, c_n, s_q0, c_q0;
  logic               vb;

  assign s_n_next = NUM_W'(s_p) + SIN_HALF;
  assign c_n_next = NUM_W'(c_p) + COS_HALF;
  assign s_qprod  = (2*NUM_W)'(s_n_next) * (2*NUM_W)'(SIN_M);
  assign c_qprod  = (2*NUM_W)'(c_n_next) * (2*NUM_W)'(COS_M);

  // Stage C: correct the quotient and fold the new term into the sums.
  logic [NUM_W-1:0]  s_rem, c_rem, s_q, c_q;
  logic [TERM_W-1:0] s_t, c_t;
  term_bus_t         bout_next;

  always_comb begin
    s_rem = s_n - NUM_W'(s_q0 * SIN_DV);
    c_rem = c_n - NUM_W'(c_q0 * COS_DV);
    s_q   = (s_rem >= SIN_DV) ? s_q0 + NUM_W'(1) : s_q0;
    c_q   = (c_rem >= COS_DV) ? c_q0 + NUM_W'(1) : c_q0;
    s_t   = TERM_W'(s_q);
    c_t   = TERM_W'(c_q);
    bout_next = bus_b;
    if (SIN_ON) begin
      bout_next.s_term = s_t;
      bout_next.s_acc  = SUBTRACT ? bus_b.s_acc - $signed({2'b00, s_t})
                                  : bus_b.s_acc + $signed({2'b00, s_t});
    end
    if (COS_ON) begin
      bout_next.c_term = c_t;
      bout_next.c_acc  = SUBTRACT ? bus_b.c_acc - $signed({2'b00, c_t})
                                  : bus_b.c_acc + $signed({2'b00, c_t});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va   <= 1'b0;
      vb   <= 1'b0;
      vout <= 1'b0;
    end else if (adv) begin
      va   <= vin;
      vb   <= va;
      vout <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bus_a <= bin;
      s_p   <= s_p_next;
      c_p   <= c_p_next;
      bus_b <= bus_a;
      s_n   <= s_n_next;
      c_n   <= c_n_next;
      s_q0  <= NUM_W'(s_qprod >> NUM_W);
      c_q0  <= NUM_W'(c_qprod >> NUM_W);
      bout  <= bout_next;
    end
  end

endmodule

@@ src/sine_cosine_taylor.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Payload                                  Request
// argument  in         angle (s32, ANGLE_FRACTION_BITS frac)    valid && ready
// result    out        sine_value, cosine_value (s24, 22 frac)  valid && ready
//
// One request is taken every cycle while the skid register is empty. The
// pipeline holds the reduction cells (one per quotient bit) and the
// three-stage term cells (one per series term pair).
// Reset clears every valid bit and the skid slot; payload registers keep data.
// A stalled result is held in the output register, one more is caught in a
// skid register, and only then does argument.ready fall.

module sine_cosine_taylor
  import sct_pkg::*;
#(
  parameter int COSINE_TERMS        = 7,
  parameter int SINE_TERMS          = 6,
  parameter int ANGLE_FRACTION_BITS = 24
) (
  input logic       clk,
  input logic       rst,
  sct_in_if.sink    argument,
  sct_out_if.source result
);

  localparam int XW    = 64 - ANGLE_FRACTION_BITS;
  localparam int YW    = XW + 1;
  localparam int J     = 29 - ANGLE_FRACTION_BITS;
  localparam int NCELL = (SINE_TERMS > COSINE_TERMS ? SINE_TERMS : COSINE_TERMS) - 1;

  localparam logic [YW-1:0]    WRAP  = YW'(TWO_PI_Q32) << J;
  localparam logic [MAG_W-1:0] A_MAX = MAG_W'((36'(PI_Q32) + 36'd8) >> 4);

  logic adv;
  logic skid_valid;
  logic ov;

  assign adv            = !skid_valid;
  assign argument.ready = adv;

  // Shift the angle to 32 fractional bits, move by pi and fold negative
  // values up by a multiple of two pi, so the cells see a non-negative value.
  logic signed [XW-1:0] x_in;
  logic [YW-1:0]        y_shift, y_sign_next;
  logic                 v_sign;
  logic [YW-1:0]        y_sign;

  assign x_in        = {argument.angle, {(32 - ANGLE_FRACTION_BITS){1'b0}}};
  assign y_shift     = {x_in[XW-1], x_in} + YW'(PI_Q32);
  assign y_sign_next = y_shift[YW-1] ? y_shift + WRAP : y_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_sign <= 1'b0;
    end else if (adv) begin
      v_sign <= argument.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y_sign <= y_sign_next;
    end
  end

  logic [YW-1:0] ychain [0:J];
  logic          vchain [0:J];

  assign ychain[0] = y_sign;
  assign vchain[0] = v_sign;

  for (genvar g = 0; g < J; g++) begin : g_reduce
    sct_reduce_cell #(
      .YW    (YW),
      .SHIFT (J - 1 - g)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .vin  (vchain[g]),
      .yin  (ychain[g]),
      .vout (vchain[g+1]),
      .yout (ychain[g+1])
    );
  end

  // The remainder lies in [0, 2pi); moving back by pi gives the reduced angle.
  logic [35:0]      r_full, r_mag;
  logic [MAG_W-1:0] a_next, a;
  logic             neg_front, v_front;

  assign r_full = {1'b0, ychain[J][34:0]} - 36'(PI_Q32);
  assign r_mag  = r_full[35] ? 36'd0 - r_full : r_full;
  assign a_next = MAG_W'((r_mag + 36'd8) >> 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_front <= 1'b0;
    end else if (adv) begin
      v_front <= vchain[J];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a         <= a_next;
      neg_front <= r_full[35];
    end
  end

  logic [59:0] sq;
  term_bus_t   bus_first;
  term_bus_t   bus_chain [0:NCELL];
  logic        tv_chain [0:NCELL];

  assign sq = 60'(a) * 60'(a);

  always_comb begin
    bus_first.s_acc  = ACC_W'(a);
    bus_first.s_term = TERM_W'(a);
    bus_first.c_acc  = ACC_W'(ONE_Q28);
    bus_first.c_term = ONE_Q28;
    bus_first.x2     = SQ_W'((sq + 60'(HALF_Q28)) >> FRAC);
    bus_first.neg    = neg_front;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tv_chain[0] <= 1'b0;
    end else if (adv) begin
      tv_chain[0] <= v_front;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bus_chain[0] <= bus_first;
    end
  end

  for (genvar k = 0; k < NCELL; k++) begin : g_term
    sct_term_cell #(
      .K      (k),
      .SIN_ON (k < SINE_TERMS - 1),
      .COS_ON (k < COSINE_TERMS - 1)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .vin  (tv_chain[k]),
      .bin  (bus_chain[k]),
      .vout (tv_chain[k+1]),
      .bout (bus_chain[k+1])
    );
  end

  // Round half away from zero to 22 fractional bits and saturate to 24 bits.
  function automatic logic [OUT_W-1:0] to_out(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] m;
    logic [ACC_W-1:0] r;
    logic [ACC_W-1:0] q;
    m = v[ACC_W-1] ? ACC_W'(0) - v : v;
    r = (m + ACC_W'(32)) >> 6;
    q = v[ACC_W-1] ? ACC_W'(0) - r : r;
    if ((&q[ACC_W-1:OUT_W-1]) || !(|q[ACC_W-1:OUT_W-1])) begin
      to_out = q[OUT_W-1:0];
    end else begin
      to_out = q[ACC_W-1] ? OUT_MIN : OUT_MAX;
    end
  endfunction

  term_bus_t               bus_last;
  logic signed [ACC_W-1:0] s_signed;
  result_t                 res_next;
  result_t                 od, skid;
  logic                    take;

  assign bus_last        = bus_chain[NCELL];
  assign s_signed        = bus_last.neg ? -bus_last.s_acc : bus_last.s_acc;
  assign res_next.sine   = to_out(s_signed);
  assign res_next.cosine = to_out(bus_last.c_acc);
  assign take            = ov && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov         <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (!ov || take) begin
      ov <= tv_chain[NCELL];
    end else if (tv_chain[NCELL]) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        od <= skid;
      end
    end else if (!ov || take) begin
      od <= res_next;
    end else begin
      skid <= res_next;
    end
  end

  assign result.valid        = ov;
  assign result.sine_value   = od.sine;
  assign result.cosine_value = od.cosine;

  a_skid_needs_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> ov)
    else $error("skid register holds a request while the output slot is empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(ov && !result.ready))
    else $error("skid register filled without a stalled output");

  a_remainder_range: assert property (@(posedge clk) disable iff (rst)
    vchain[J] |-> ychain[J] < YW'(TWO_PI_Q32))
    else $error("reduction left a remainder of two pi or more");

  a_magnitude_range: assert property (@(posedge clk) disable iff (rst)
    v_front |-> a <= A_MAX)
    else $error("reduced angle magnitude exceeds pi");

endmodule
